@@ rtl/gregorian_days_between_dates_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian day difference block
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAYS_BETWEEN_DATES_MACROS_SVH
`define GREGORIAN_DAYS_BETWEEN_DATES_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define GDBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define GDBD_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`else

`define GDBD_ASSERT(lbl, prop, msg)
`define GDBD_ASSERT_NEVER(lbl, prop, msg)

`endif

`endif

@@ rtl/gdbd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdbd_pkg
// Types, constants and calendar tables shared by the day difference block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdbd_pkg;

  localparam int unsigned DayW     = 5;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned YearW    = 14;
  localparam int unsigned CountW   = 22;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned DayNumW  = 23;
  localparam int unsigned CentW    = 8;
  localparam int unsigned YearCmpW = 16;

  localparam int unsigned MaxYearDefault = 9999;
  localparam int unsigned MonthsPerYear  = 12;
  localparam int unsigned DaysPerYear    = 365;
  localparam int unsigned YearsPerCent   = 100;

  // floor(y / 100) as (y * Recip100) >> RecipShift, exact for y below 43690.
  localparam int unsigned Recip100   = 10486;
  localparam int unsigned RecipW     = 14;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned ProdW      = YearW + RecipW;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusOrder    = 2'd1;
  localparam logic [StatusW-1:0] StatusInvalid  = 2'd2;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   last_day;
    logic [MonthW-1:0] last_month;
    logic [YearW-1:0]  last_year;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0]  day_count;
    logic [StatusW-1:0] status;
  } res_t;

  // One date after the range checks, split into the terms of its day number.
  typedef struct packed {
    logic              ok;
    logic              leap;
    logic [YearW-1:0]  prev_year;
    logic [CentW-1:0]  prev_cent;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } check_t;

  typedef struct packed {
    logic               ok;
    logic [DayNumW-1:0] num;
  } num_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/gdbd_date_check.sv @@
// ----------------------------------------------------------------------------
// gdbd_date_check
// Two stages per date: the century quotient by reciprocal multiplication,
// then the leap rule, the range checks and the previous-year terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdbd_date_check #(
  parameter int unsigned MAX_YEAR = gdbd_pkg::MaxYearDefault
) (
  input  logic                         clk_i,
  input  logic [gdbd_pkg::DayW-1:0]    day_i,
  input  logic [gdbd_pkg::MonthW-1:0]  month_i,
  input  logic [gdbd_pkg::YearW-1:0]   year_i,
  output gdbd_pkg::check_t             chk_o
);
  import gdbd_pkg::*;

  localparam logic [YearCmpW-1:0] MaxYearW = YearCmpW'(MAX_YEAR);

  // Stage one.
  logic [ProdW-1:0]  prod;
  logic [DayW-1:0]   day_q;
  logic [MonthW-1:0] month_q;
  logic [YearW-1:0]  year_q;
  logic [CentW-1:0]  cent_q;

  assign prod = ProdW'(year_i) * ProdW'(Recip100);

  always_ff @(posedge clk_i) begin
    day_q   <= day_i;
    month_q <= month_i;
    year_q  <= year_i;
    cent_q  <= prod[RecipShift +: CentW];
  end

  // Stage two.
  logic [YearW-1:0] rem100;
  logic             century;
  logic             leap;
  logic [DayW-1:0]  lim;
  logic             year_ok;
  logic             month_ok;
  logic             day_ok;
  check_t           chk_d;
  check_t           chk_q;

  always_comb begin
    rem100   = year_q - YearW'(YearW'(cent_q) * YearW'(YearsPerCent));
    century  = (rem100 == '0);
    leap     = (year_q[1:0] == 2'b00) && (!century || (cent_q[1:0] == 2'b00));
    lim      = month_len(month_q) + DayW'((month_q == 4'd2) && leap);
    year_ok  = (year_q != '0) && (YearCmpW'(year_q) <= MaxYearW);
    month_ok = (month_q != '0) && (month_q <= MonthW'(MonthsPerYear));
    day_ok   = (day_q != '0) && (day_q <= lim);

    chk_d.ok        = year_ok && month_ok && day_ok;
    chk_d.leap      = leap;
    chk_d.prev_year = year_q - YearW'(1);
    // The year before a century year lies in the previous century.
    chk_d.prev_cent = cent_q - CentW'(century);
    chk_d.month     = month_q;
    chk_d.day       = day_q;
  end

  always_ff @(posedge clk_i) begin
    chk_q <= chk_d;
  end

  assign chk_o = chk_q;

endmodule

@@ rtl/gdbd_day_number.sv @@
// ----------------------------------------------------------------------------
// gdbd_day_number
// Third stage: the day number of a checked date, counted from 1 January of
// year one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdbd_day_number (
  input  logic             clk_i,
  input  gdbd_pkg::check_t chk_i,
  output gdbd_pkg::num_t   num_o
);
  import gdbd_pkg::*;

  num_t num_d;
  num_t num_q;

  always_comb begin
    num_d.ok  = chk_i.ok;
    num_d.num = DayNumW'(chk_i.prev_year) * DayNumW'(DaysPerYear)
              + DayNumW'(chk_i.prev_year >> 2)
              - DayNumW'(chk_i.prev_cent)
              + DayNumW'(chk_i.prev_cent >> 2)
              + DayNumW'(days_before(chk_i.month))
              + DayNumW'((chk_i.month > 4'd2) && chk_i.leap)
              + DayNumW'(chk_i.day)
              - DayNumW'(1);
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign num_o = num_q;

endmodule

@@ rtl/gregorian_days_between_dates.sv @@
// ----------------------------------------------------------------------------
// gregorian_days_between_dates
// Each accepted word passes the century, check, day number and result
// registers in that order; the result strobe rises with the result word.
// Throughput: one word per cycle; busy stays low, so start may be held high.
// The four stages are the century multiply, the date checks, the day number
// sum and the final compare and subtract.
// Reset clears the valid bits only; no result appears until a word enters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gregorian_days_between_dates_macros.svh"

module gregorian_days_between_dates #(
  parameter int unsigned MAX_YEAR = gdbd_pkg::MaxYearDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  gdbd_pkg::req_t req_i,
  output logic           valid_o,
  output gdbd_pkg::res_t res_o
);
  import gdbd_pkg::*;

  logic     accept;
  check_t   chk_a;
  check_t   chk_b;
  num_t     num_a;
  num_t     num_b;
  logic [2:0] vld_d;
  logic [2:0] vld_q;
  logic     valid_q;
  res_t     res_d;
  res_t     res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  gdbd_date_check #(.MAX_YEAR(MAX_YEAR)) u_check_a (
    .clk_i   (clk_i),
    .day_i   (req_i.first_day),
    .month_i (req_i.first_month),
    .year_i  (req_i.first_year),
    .chk_o   (chk_a)
  );

  gdbd_date_check #(.MAX_YEAR(MAX_YEAR)) u_check_b (
    .clk_i   (clk_i),
    .day_i   (req_i.last_day),
    .month_i (req_i.last_month),
    .year_i  (req_i.last_year),
    .chk_o   (chk_b)
  );

  gdbd_day_number u_num_a (
    .clk_i (clk_i),
    .chk_i (chk_a),
    .num_o (num_a)
  );

  gdbd_day_number u_num_b (
    .clk_i (clk_i),
    .chk_i (chk_b),
    .num_o (num_b)
  );

  assign vld_d = {vld_q[1:0], accept};

  // Validity takes precedence over the order of the two dates.
  always_comb begin
    res_d.day_count = '0;
    res_d.status    = StatusOk;
    if (!(num_a.ok && num_b.ok)) begin
      res_d.status = StatusInvalid;
    end else if (num_a.num > num_b.num) begin
      res_d.status = StatusOrder;
    end else begin
      res_d.day_count = CountW'(num_b.num - num_a.num);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      valid_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `GDBD_ASSERT(a_latency, accept |-> ##4 valid_o, "accepted word did not reach the output")
  `GDBD_ASSERT(a_err_zero, (valid_o && (res_o.status != StatusOk)) |-> (res_o.day_count == '0),
               "error result with non-zero day count")
  `GDBD_ASSERT(a_status_code, valid_o |-> ((res_o.status == StatusOk) ||
               (res_o.status == StatusOrder) || (res_o.status == StatusInvalid)),
               "undefined status code")
  `GDBD_ASSERT_NEVER(a_no_spurious, valid_o && !$past(vld_q[2]), "result strobe without a word in flight")

endmodule

@@ tb/tb_gregorian_days_between_dates.sv @@
// ----------------------------------------------------------------------------
// Testbench for the Gregorian day difference block
// Sends pairs of dates in bursts with random gaps between them and predicts
// each day count and status from closed-form day numbers. The predictions
// are queued as each word is accepted, and every strobed result is compared
// with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gregorian_days_between_dates;

  import gdbd_pkg::*;

  localparam int unsigned NumItems   = 1650;
  localparam int unsigned Latency    = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned MaxYear    = MaxYearDefault;
  localparam int unsigned ReqW       = $bits(req_t);

  class day_span_scoreboard;
    res_t        due_q[$];
    int unsigned words_in;
    int unsigned spans_seen;
    int unsigned mismatches;
    int unsigned ordered_seen;
    int unsigned reversed_seen;
    int unsigned invalid_seen;
    int unsigned len_tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function bit is_leap(int unsigned y);
      if (y % 4 != 0) return 1'b0;
      if (y % 100 != 0) return 1'b1;
      return (y % 400) == 0;
    endfunction

    function int unsigned days_in_month(int unsigned m, int unsigned y);
      if (m == 2 && is_leap(y)) return 29;
      return len_tab[m - 1];
    endfunction

    function bit date_valid(int unsigned d, int unsigned m, int unsigned y);
      if (y < 1 || y > MaxYear) return 1'b0;
      if (m < 1 || m > 12) return 1'b0;
      return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // Day 0 is 1 January of year 1.
    function int unsigned day_index(int unsigned d, int unsigned m, int unsigned y);
      int unsigned p;
      int unsigned n;
      p = y - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400;
      for (int unsigned k = 1; k < m; k++) n += days_in_month(k, y);
      return n + d - 1;
    endfunction

    function res_t predict_span(req_t r);
      res_t        e;
      int unsigned a;
      int unsigned b;
      e = '0;
      if (!date_valid(r.first_day, r.first_month, r.first_year) ||
          !date_valid(r.last_day, r.last_month, r.last_year)) begin
        e.status = StatusInvalid;
        return e;
      end
      a = day_index(r.first_day, r.first_month, r.first_year);
      b = day_index(r.last_day, r.last_month, r.last_year);
      if (a > b) begin
        e.status = StatusOrder;
        return e;
      end
      e.day_count = CountW'(b - a);
      e.status    = StatusOk;
      return e;
    endfunction

    function void note_dates(req_t r);
      due_q.push_back(predict_span(r));
      words_in++;
    endfunction

    function void check_span(res_t got);
      res_t want;
      spans_seen++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("Unexpected result word: count %0d status %0d",
                   got.day_count, got.status);
        return;
      end
      want = due_q.pop_front();
      if (want.day_count !== got.day_count || want.status !== got.status) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("Mismatch on word %0d: expected count %0d status %0d, got count %0d status %0d",
                   spans_seen, want.day_count, want.status, got.day_count, got.status);
      end
      case (want.status)
        StatusOk:      ordered_seen++;
        StatusOrder:   reversed_seen++;
        StatusInvalid: invalid_seen++;
        default: ;
      endcase
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  req_t        req_i  = '0;
  logic        busy;
  logic        valid_o;
  res_t        res_o;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;

  day_span_scoreboard sb = new();

  gregorian_days_between_dates dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Accepted words and strobed results, both sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_dates(req_i);
    if (rst_ni && valid_o) sb.check_span(res_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, sb.due_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic req_t pack_dates(int unsigned d1, int unsigned m1, int unsigned y1,
                                      int unsigned d2, int unsigned m2, int unsigned y2);
    req_t r;
    r.first_day   = DayW'(d1);
    r.first_month = MonthW'(m1);
    r.first_year  = YearW'(y1);
    r.last_day    = DayW'(d2);
    r.last_month  = MonthW'(m2);
    r.last_year   = YearW'(y2);
    return r;
  endfunction

  function automatic int unsigned pick_year();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(1, MaxYear);
    // Years close to a century, where the leap rule changes.
    if (sel < 8) return $urandom_range(1, 99) * 100 + $urandom_range(0, 4) - 2;
    if (sel == 8) return $urandom_range(1, 10);
    return $urandom_range(MaxYear - 9, MaxYear);
  endfunction

  function automatic void pick_date(output int unsigned d, output int unsigned m,
                                    output int unsigned y);
    y = pick_year();
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.days_in_month(m, y));
    // Lean towards the month ends.
    if ($urandom_range(0, 5) == 0) d = sb.days_in_month(m, y);
  endfunction

  function automatic req_t random_pair();
    int unsigned d1, m1, y1, d2, m2, y2, t;
    int unsigned sel;
    req_t        r;
    pick_date(d1, m1, y1);
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      pick_date(d2, m2, y2);
    end else if (sel < 7) begin
      y2 = y1;
      m2 = $urandom_range(1, 12);
      d2 = $urandom_range(1, sb.days_in_month(m2, y2));
    end else begin
      y2 = y1;
      m2 = m1;
      d2 = $urandom_range(1, sb.days_in_month(m2, y2));
    end
    // Put the pair in order, or deliberately out of order now and then.
    if (({y1, m1, d1} > {y2, m2, d2}) == ($urandom_range(0, 99) >= 12)) begin
      t = d1; d1 = d2; d2 = t;
      t = m1; m1 = m2; m2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    r = pack_dates(d1, m1, y1, d2, m2, y2);
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 6))
        0: r.first_day   = DayW'($urandom_range(0, 31));
        1: r.first_month = MonthW'($urandom_range(0, 15));
        2: r.first_year  = YearW'($urandom_range(0, 16383));
        3: r.last_day    = DayW'($urandom_range(0, 31));
        4: r.last_month  = MonthW'($urandom_range(0, 15));
        5: r.last_year   = YearW'($urandom_range(0, 16383));
        default: r = req_t'(ReqW'({$urandom, $urandom}));
      endcase
    end
    return r;
  endfunction

  // Holds start high until the word has been taken.
  task automatic send_dates(input req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic pause(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic run_directed();
    send_dates(pack_dates(1, 1, 1, 1, 1, 1));
    send_dates(pack_dates(1, 1, 1, 31, 12, MaxYear));
    send_dates(pack_dates(31, 12, MaxYear, 1, 1, 1));
    send_dates(pack_dates(1, 1, 2000, 1, 1, 2001));
    send_dates(pack_dates(28, 2, 1900, 1, 3, 1900));
    send_dates(pack_dates(29, 2, 1900, 1, 3, 1900));
    send_dates(pack_dates(29, 2, 2000, 1, 3, 2000));
    send_dates(pack_dates(29, 2, 2004, 29, 2, 2008));
    send_dates(pack_dates(1, 3, 2100, 29, 2, 2100));
    send_dates(pack_dates(29, 2, 2400, 31, 12, 2400));
    send_dates(pack_dates(0, 5, 1500, 1, 6, 1500));
    send_dates(pack_dates(1, 0, 1500, 1, 6, 1500));
    send_dates(pack_dates(1, 13, 1500, 1, 6, 1600));
    send_dates(pack_dates(1, 1, 1500, 1, 15, 1600));
    send_dates(pack_dates(1, 1, 0, 1, 1, 5));
    send_dates(pack_dates(1, 1, 5, 1, 1, MaxYear + 1));
    send_dates(pack_dates(31, 15, 16383, 31, 15, 16383));
    send_dates(pack_dates(31, 4, 2022, 1, 5, 2022));
    send_dates(pack_dates(1, 10, 2022, 31, 11, 2022));
    send_dates(pack_dates(31, 1, 1, 31, 12, 1));
    send_dates(pack_dates(16, 6, 2023, 15, 6, 2023));
    // An invalid date wins over a reversed pair.
    send_dates(pack_dates(30, 2, 50, 1, 1, 10));
    send_dates(pack_dates(31, 12, 1999, 1, 1, 2000));
    send_dates(pack_dates(1, 1, MaxYear, 31, 12, MaxYear));
    send_dates(pack_dates(15, 6, 2023, 15, 6, 2023));
  endtask

  task automatic run_random();
    int unsigned burst;
    while (sent < NumItems) begin
      if ($urandom_range(0, 7) == 0) burst = $urandom_range(40, 80);
      else burst = $urandom_range(1, 24);
      repeat (burst) send_dates(random_pair());
      pause($urandom_range(1, 7));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    pause($urandom_range(1, 5));
    run_random();
    start <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    $display("Sent %0d date pairs; results: %0d in order, %0d reversed, %0d invalid.",
             sb.words_in, sb.ordered_seen, sb.reversed_seen, sb.invalid_seen);
    $display("Result words seen: %0d, mismatches: %0d, still waiting: %0d.",
             sb.spans_seen, sb.mismatches, sb.due_q.size());
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gdbd_pkg.sv
rtl/gdbd_date_check.sv
rtl/gdbd_day_number.sv
rtl/gregorian_days_between_dates.sv
tb/tb_gregorian_days_between_dates.sv
